// ===== rtl/core/thpc_pkg.sv =====
// ----------------------------------------------------------------------------
// thpc_pkg
// Shared constants and types for the thermal pixel calibration unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package thpc_pkg;

   localparam int unsigned HEADER_WORDS = 64;
   localparam int unsigned PIXEL_COUNT  = 768;

   localparam logic [15:0] BROKEN_WORD = 16'h7FFF;

   // header word addresses
   localparam logic [5:0] HDR_OFS_SCALE = 6'd0;
   localparam logic [5:0] HDR_OFS_REF   = 6'd1;
   localparam logic [5:0] HDR_OFS_ROW   = 6'd2;
   localparam logic [5:0] HDR_OFS_COL   = 6'd8;
   localparam logic [5:0] HDR_ALP_ROW   = 6'd18;
   localparam logic [5:0] HDR_ALP_COL   = 6'd24;
   localparam logic [5:0] HDR_ALP_SCALE = 6'd32;
   localparam logic [5:0] HDR_ALP_REF   = 6'd33;
   localparam logic [5:0] HDR_KV_BASE   = 6'd52;
   localparam logic [5:0] HDR_KTA_EVEN  = 6'd54;
   localparam logic [5:0] HDR_KTA_ODD   = 6'd55;
   localparam logic [5:0] HDR_KTA_SCALE = 6'd56;

   localparam int unsigned ROW_WORDS = 6;
   localparam int unsigned COL_WORDS = 8;

   // header fields picked for one pixel
   typedef struct packed {
      logic [15:0] ofs_scale;
      logic [15:0] ofs_ref;
      logic [3:0]  ofs_row_nib;
      logic [3:0]  ofs_col_nib;
      logic [15:0] alp_scale;
      logic [15:0] alp_ref;
      logic [3:0]  alp_row_nib;
      logic [3:0]  alp_col_nib;
      logic [7:0]  kta_base;
      logic [3:0]  kta_shift;
      logic [3:0]  kv_base;
   } hdr_snap_type;

endpackage

`default_nettype wire

// ===== rtl/core/thpc_hdr.sv =====
// ----------------------------------------------------------------------------
// thpc_hdr
// Header word store; presents the fields one pixel needs by row and column.
// ----------------------------------------------------------------------------
`default_nettype none

module thpc_hdr (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [5:0]             wr_addr,
   input  wire logic [15:0]            wr_data,
   input  wire logic [4:0]             rd_row,
   input  wire logic [4:0]             rd_col,
   output thpc_pkg::hdr_snap_type      snap
);

   logic [15:0] ofs_scale_ff, ofs_ref_ff, alp_scale_ff, alp_ref_ff;
   logic [15:0] kv_base_ff, kta_even_ff, kta_odd_ff, kta_scale_ff;
   logic [15:0] ofs_row_ff [thpc_pkg::ROW_WORDS];
   logic [15:0] ofs_col_ff [thpc_pkg::COL_WORDS];
   logic [15:0] alp_row_ff [thpc_pkg::ROW_WORDS];
   logic [15:0] alp_col_ff [thpc_pkg::COL_WORDS];

   logic [5:0] ofs_row_off, alp_row_off;
   logic [15:0] kta_word;
   logic [1:0] par;

   function automatic logic [3:0] nib_sel(input logic [15:0] w, input logic [1:0] k);
      logic [3:0] r;
      case (k)
         2'd0: r = w[15:12];
         2'd1: r = w[11:8];
         2'd2: r = w[7:4];
         default: r = w[3:0];
      endcase
      return r;
   endfunction

   assign ofs_row_off = wr_addr - thpc_pkg::HDR_OFS_ROW;
   assign alp_row_off = wr_addr - thpc_pkg::HDR_ALP_ROW;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_addr == thpc_pkg::HDR_OFS_SCALE) ofs_scale_ff <= wr_data;
         if (wr_addr == thpc_pkg::HDR_OFS_REF)   ofs_ref_ff   <= wr_data;
         if (wr_addr == thpc_pkg::HDR_ALP_SCALE) alp_scale_ff <= wr_data;
         if (wr_addr == thpc_pkg::HDR_ALP_REF)   alp_ref_ff   <= wr_data;
         if (wr_addr == thpc_pkg::HDR_KV_BASE)   kv_base_ff   <= wr_data;
         if (wr_addr == thpc_pkg::HDR_KTA_EVEN)  kta_even_ff  <= wr_data;
         if (wr_addr == thpc_pkg::HDR_KTA_ODD)   kta_odd_ff   <= wr_data;
         if (wr_addr == thpc_pkg::HDR_KTA_SCALE) kta_scale_ff <= wr_data;
         if (wr_addr >= thpc_pkg::HDR_OFS_ROW &&
             wr_addr <  thpc_pkg::HDR_OFS_ROW + 6'(thpc_pkg::ROW_WORDS)) begin
            ofs_row_ff[ofs_row_off[2:0]] <= wr_data;
         end
         if (wr_addr >= thpc_pkg::HDR_OFS_COL &&
             wr_addr <  thpc_pkg::HDR_OFS_COL + 6'(thpc_pkg::COL_WORDS)) begin
            ofs_col_ff[wr_addr[2:0]] <= wr_data;
         end
         if (wr_addr >= thpc_pkg::HDR_ALP_ROW &&
             wr_addr <  thpc_pkg::HDR_ALP_ROW + 6'(thpc_pkg::ROW_WORDS)) begin
            alp_row_ff[alp_row_off[2:0]] <= wr_data;
         end
         if (wr_addr >= thpc_pkg::HDR_ALP_COL &&
             wr_addr <  thpc_pkg::HDR_ALP_COL + 6'(thpc_pkg::COL_WORDS)) begin
            alp_col_ff[wr_addr[2:0]] <= wr_data;
         end
      end
   end

   assign par      = {rd_row[0], rd_col[0]};
   assign kta_word = rd_row[0] ? kta_odd_ff : kta_even_ff;

   always_comb begin
      snap.ofs_scale   = ofs_scale_ff;
      snap.ofs_ref     = ofs_ref_ff;
      snap.ofs_row_nib = nib_sel(ofs_row_ff[rd_row[4:2]], rd_row[1:0]);
      snap.ofs_col_nib = nib_sel(ofs_col_ff[rd_col[4:2]], rd_col[1:0]);
      snap.alp_scale   = alp_scale_ff;
      snap.alp_ref     = alp_ref_ff;
      snap.alp_row_nib = nib_sel(alp_row_ff[rd_row[4:2]], rd_row[1:0]);
      snap.alp_col_nib = nib_sel(alp_col_ff[rd_col[4:2]], rd_col[1:0]);
      snap.kta_base    = rd_col[0] ? kta_word[7:0] : kta_word[15:8];
      snap.kta_shift   = kta_scale_ff[3:0];
      snap.kv_base     = nib_sel(kv_base_ff, par);
   end

endmodule

`default_nettype wire

// ===== rtl/core/thermal_pixel_calib_unpack.sv =====
// ----------------------------------------------------------------------------
// thermal_pixel_calib_unpack
// Stores calibration header words and unpacks each pixel word into offset,
// alpha, kta, kv and broken/outlier flags.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    word_index, ee_word
//   rsp      out  rsp_valid/rsp_ready    pixel_index, offset, alpha, kta, kv,
//                                        broken, outlier
//
// One request per cycle unless the pipeline is full behind a stalled response; a pixel
// result passes four stages (snapshot, shift terms, sums and kta divide, final scale shift).
// Header words are written at accept and give no response.
// Each stage holds while the stage after it is full and stalled; bubbles
// collapse, so requests keep flowing while a response waits.
// Synchronous active-high reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_pixel_calib_unpack (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [9:0]         req_word_index,
   input  wire logic [15:0]        req_ee_word,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [9:0]              rsp_pixel_index,
   output logic signed [15:0]      rsp_pixel_offset,
   output logic [15:0]             rsp_pixel_alpha,
   output logic signed [7:0]       rsp_pixel_kta,
   output logic signed [7:0]       rsp_pixel_kv,
   output logic                    rsp_pixel_broken,
   output logic                    rsp_pixel_outlier
);

   localparam logic [9:0] HDR_END = 10'(thpc_pkg::HEADER_WORDS);
   localparam logic [9:0] PIX_END = 10'(thpc_pkg::HEADER_WORDS + thpc_pkg::PIXEL_COUNT);

   logic rdy1, rdy2, rdy3, rdy4;
   logic req_fire, is_hdr, is_pix;
   logic [9:0] pix_in;
   thpc_pkg::hdr_snap_type snap_in;

   // stage 1: captured request and header fields
   logic                   v1_ff;
   logic [9:0]             pix1_ff;
   logic [15:0]            word1_ff;
   thpc_pkg::hdr_snap_type snap1_ff;

   // stage 2: shifted terms
   logic                   v2_ff;
   logic [9:0]             pix2_ff;
   logic [15:0]            ofs_t0_ff, ofs_t1_ff, ofs_t2_ff, ofs_t3_ff;
   logic [3:0]             ofs_sh2_ff;
   logic [21:0]            alp_t0_ff, alp_t1_ff, alp_t2_ff, alp_t3_ff;
   logic [3:0]             alp_sh2_ff;
   logic [23:0]            kta_x2_ff;
   logic [3:0]             kta_sh2_ff;
   logic [7:0]             kv2_ff;
   logic                   brk2_ff, out2_ff;
   logic [15:0]            ofs_t1_in, ofs_t2_in, ofs_t3_in;
   logic [21:0]            alp_t1_in, alp_t2_in, alp_t3_in;
   logic [23:0]            kta_x2_in;
   logic [7:0]             kv2_in;
   logic                   brk2_in;

   // stage 3: sums and kta quotient
   logic                   v3_ff;
   logic [9:0]             pix3_ff;
   logic [15:0]            ofs_sum3_ff;
   logic [3:0]             ofs_sh3_ff;
   logic [21:0]            alp_sum3_ff;
   logic [3:0]             alp_sh3_ff;
   logic [7:0]             kta3_ff, kv3_ff;
   logic                   brk3_ff, out3_ff;
   logic [23:0]            kta_q_in, kta_mask;
   logic [7:0]             kta3_in;

   // stage 4: response register
   logic                   v4_ff;
   logic [9:0]             pix4_ff;
   logic [15:0]            ofs4_ff, alp4_ff;
   logic [7:0]             kta4_ff, kv4_ff;
   logic                   brk4_ff, out4_ff;
   logic signed [21:0]     alp_shr;

   assign rdy4 = !v4_ff || rsp_ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_ready = rdy1;

   assign req_fire = req_valid && req_ready;
   assign is_hdr   = req_word_index < HDR_END;
   assign is_pix   = !is_hdr && req_word_index < PIX_END;
   assign pix_in   = req_word_index - HDR_END;

   thpc_hdr u_hdr (
      .clock   (clock),
      .wr_en   (req_fire && is_hdr),
      .wr_addr (req_word_index[5:0]),
      .wr_data (req_ee_word),
      .rd_row  (pix_in[9:5]),
      .rd_col  (pix_in[4:0]),
      .snap    (snap_in)
   );

   // ---- stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_valid && is_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         pix1_ff  <= pix_in;
         word1_ff <= req_ee_word;
         snap1_ff <= snap_in;
      end
   end

   // ---- stage 2
   always_comb begin
      ofs_t1_in = {{12{snap1_ff.ofs_row_nib[3]}}, snap1_ff.ofs_row_nib}
                  << snap1_ff.ofs_scale[11:8];
      ofs_t2_in = {{12{snap1_ff.ofs_col_nib[3]}}, snap1_ff.ofs_col_nib}
                  << snap1_ff.ofs_scale[7:4];
      ofs_t3_in = {{10{word1_ff[15]}}, word1_ff[15:10]} << snap1_ff.ofs_scale[3:0];
      alp_t1_in = {{18{snap1_ff.alp_row_nib[3]}}, snap1_ff.alp_row_nib}
                  << snap1_ff.alp_scale[11:8];
      alp_t2_in = {{18{snap1_ff.alp_col_nib[3]}}, snap1_ff.alp_col_nib}
                  << snap1_ff.alp_scale[7:4];
      alp_t3_in = {18'd0, word1_ff[9:6]} << snap1_ff.alp_scale[3:0];
      kta_x2_in = ({{16{snap1_ff.kta_base[7]}}, snap1_ff.kta_base} << snap1_ff.kta_shift)
                  + {{22{word1_ff[5]}}, word1_ff[5:4]};
      kv2_in    = {{4{snap1_ff.kv_base[3]}}, snap1_ff.kv_base}
                  + {{5{word1_ff[3]}}, word1_ff[3:1]};
      brk2_in   = word1_ff == thpc_pkg::BROKEN_WORD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         pix2_ff    <= pix1_ff;
         ofs_t0_ff  <= snap1_ff.ofs_ref;
         ofs_t1_ff  <= ofs_t1_in;
         ofs_t2_ff  <= ofs_t2_in;
         ofs_t3_ff  <= ofs_t3_in;
         ofs_sh2_ff <= snap1_ff.ofs_scale[15:12];
         alp_t0_ff  <= {6'd0, snap1_ff.alp_ref};
         alp_t1_ff  <= alp_t1_in;
         alp_t2_ff  <= alp_t2_in;
         alp_t3_ff  <= alp_t3_in;
         alp_sh2_ff <= snap1_ff.alp_scale[15:12];
         kta_x2_ff  <= kta_x2_in;
         kta_sh2_ff <= snap1_ff.kta_shift;
         kv2_ff     <= kv2_in;
         brk2_ff    <= brk2_in;
         out2_ff    <= !brk2_in && word1_ff[0];
      end
   end

   // ---- stage 3: kta divide truncates toward zero
   always_comb begin
      kta_mask = ~(24'hFF_FFFF << kta_sh2_ff);
      kta_q_in = 24'($signed(kta_x2_ff) >>> kta_sh2_ff);
      if (kta_x2_ff[23] && (kta_x2_ff & kta_mask) != 24'd0) begin
         kta_q_in = kta_q_in + 24'd1;
      end
      kta3_in = kta_q_in[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         pix3_ff     <= pix2_ff;
         ofs_sum3_ff <= ofs_t0_ff + ofs_t1_ff + ofs_t2_ff + ofs_t3_ff;
         ofs_sh3_ff  <= ofs_sh2_ff;
         alp_sum3_ff <= alp_t0_ff + alp_t1_ff + alp_t2_ff + alp_t3_ff;
         alp_sh3_ff  <= alp_sh2_ff;
         kta3_ff     <= kta3_in;
         kv3_ff      <= kv2_ff;
         brk3_ff     <= brk2_ff;
         out3_ff     <= out2_ff;
      end
   end

   // ---- stage 4
   assign alp_shr = $signed(alp_sum3_ff) >>> alp_sh3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (rdy4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         pix4_ff <= pix3_ff;
         ofs4_ff <= ofs_sum3_ff << ofs_sh3_ff;
         alp4_ff <= alp_shr[15:0];
         kta4_ff <= kta3_ff;
         kv4_ff  <= kv3_ff;
         brk4_ff <= brk3_ff;
         out4_ff <= out3_ff;
      end
   end

   assign rsp_valid         = v4_ff;
   assign rsp_pixel_index   = pix4_ff;
   assign rsp_pixel_offset  = ofs4_ff;
   assign rsp_pixel_alpha   = alp4_ff;
   assign rsp_pixel_kta     = kta4_ff;
   assign rsp_pixel_kv      = kv4_ff;
   assign rsp_pixel_broken  = brk4_ff;
   assign rsp_pixel_outlier = out4_ff;

endmodule

`default_nettype wire

// ===== rtl/core/thpc_chk.sv =====
// ----------------------------------------------------------------------------
// thpc_chk
// Port-level checks for the thermal pixel calibration unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

module thpc_chk (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [9:0]         rsp_pixel_index,
   input wire logic signed [15:0] rsp_pixel_offset,
   input wire logic [15:0]        rsp_pixel_alpha,
   input wire logic signed [7:0]  rsp_pixel_kta,
   input wire logic signed [7:0]  rsp_pixel_kv,
   input wire logic               rsp_pixel_broken,
   input wire logic               rsp_pixel_outlier
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_index)
         && $stable(rsp_pixel_offset) && $stable(rsp_pixel_alpha)
         && $stable(rsp_pixel_kta) && $stable(rsp_pixel_kv))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // input only backs up behind a stalled response
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a waiting response");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_index < 10'(thpc_pkg::PIXEL_COUNT))
      else $error("pixel index out of range");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_broken |-> !rsp_pixel_outlier)
      else $error("pixel both broken and outlier");

endmodule

bind thermal_pixel_calib_unpack thpc_chk u_thpc_chk (.*);

`default_nettype wire
